// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; the including module supplies clk and rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge of clk outside reset.
`define ADV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ADV_ASSERT_NEVER(label, cond) \
  `ADV_ASSERT(label, !(cond))

`else

`define ADV_ASSERT(label, prop)
`define ADV_ASSERT_NEVER(label, cond)

`endif

`endif

// File: sv/adv_pkg.sv
// ----------------------------------------------------------------------------
// adv_pkg
// Shared types and constants of the asset directory validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adv_pkg;

  localparam int MAX_ENTRIES  = 1024;
  localparam int RECORD_BYTES = 64;
  localparam int ALIGN_BYTES  = 512;
  localparam int ALIGN_LOG    = $clog2(ALIGN_BYTES);

  // Record count is capped by both MAX_ENTRIES and the 10-bit record number.
  localparam int ENTRY_CAP = (MAX_ENTRIES < 1024) ? MAX_ENTRIES : 1024;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;

  // Configuration register indexes
  localparam logic [1:0] CFG_FILE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_ENTRIES     = 2'd1;
  localparam logic [1:0] CFG_DATA_START  = 2'd2;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_UNTERMINATED = 4'd1,
    ERR_ID_MISMATCH  = 4'd2,
    ERR_ORDER        = 4'd3,
    ERR_BELOW_DATA   = 4'd4,
    ERR_MISALIGNED   = 4'd5,
    ERR_SIZE         = 4'd6,
    ERR_BEYOND_END   = 4'd7,
    ERR_OVERLAP      = 4'd8
  } err_code_t;

  typedef struct packed {
    logic [31:0] file_length;
    logic [10:0] entries;
    logic [31:0] data_start;
  } cfg_t;

  // One directory byte handed to the parser
  typedef struct packed {
    logic       step;
    logic [7:0] data;
    logic       restart;
  } byte_req_t;

  // Fields of a completed record
  typedef struct packed {
    logic [9:0]  number;
    logic        is_last;
    logic [31:0] id;
    logic [31:0] offset;
    logic [31:0] packed_len;
    logic [31:0] unpacked_len;
    logic [31:0] hash;
    logic        name_ended;
  } record_t;

  typedef struct packed {
    logic [9:0]  number;
    logic [31:0] id;
    err_code_t   code;
    logic        all_ok;
    logic        last;
  } verdict_t;

endpackage

`default_nettype wire

// File: sv/adv_parser.sv
// ----------------------------------------------------------------------------
// adv_parser
// Byte position tracking, field assembly and FNV-1a name hash per record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adv_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire adv_pkg::byte_req_t req,
  input  wire logic [10:0]       entries,
  output logic                   ends_record,
  output adv_pkg::record_t       rec
);

  localparam logic [5:0] ID_FIRST   = 6'd8;
  localparam logic [5:0] OFS_FIRST  = 6'd12;
  localparam logic [5:0] PK_FIRST   = 6'd16;
  localparam logic [5:0] UPK_FIRST  = 6'd20;
  localparam logic [5:0] UPK_END    = 6'd24;
  localparam logic [5:0] NAME_FIRST = 6'd28;
  localparam logic [5:0] NAME_END   = 6'd60;
  localparam logic [5:0] POS_LAST   = 6'(adv_pkg::RECORD_BYTES - 1);
  localparam logic [10:0] CAP       = 11'(adv_pkg::ENTRY_CAP);

  logic [5:0]  pos, pos_c, pos_next;
  logic [9:0]  counter, counter_c, counter_next;
  logic [31:0] hash, hash_c, hash_next;
  logic        ended, ended_c, ended_next;
  logic        done, done_c, done_next;
  logic [31:0] id_field, id_field_next;
  logic [31:0] offset_field, offset_field_next;
  logic [31:0] packed_field, packed_field_next;
  logic [31:0] unpacked_field, unpacked_field_next;
  logic [10:0] total;
  logic        is_last;

  // FNV-1a step; the prime is 2^24 + 2^8 + 0x93, so shifts and adds suffice.
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

  always_comb begin
    total = (entries == 11'd0) ? 11'd1 : entries;
    if (total > CAP) begin
      total = CAP;
    end
  end

  assign is_last     = ({1'b0, counter} + 11'd1) >= total;
  assign ends_record = (pos == POS_LAST) && !done;

  always_comb begin
    pos_c     = req.restart ? 6'd0 : pos;
    counter_c = req.restart ? 10'd0 : counter;
    hash_c    = req.restart ? adv_pkg::FNV_BASIS : hash;
    ended_c   = req.restart ? 1'b0 : ended;
    done_c    = req.restart ? 1'b0 : done;

    pos_next            = pos_c;
    counter_next        = counter_c;
    hash_next           = hash_c;
    ended_next          = ended_c;
    done_next           = done_c;
    id_field_next       = id_field;
    offset_field_next   = offset_field;
    packed_field_next   = packed_field;
    unpacked_field_next = unpacked_field;

    if (!done_c) begin
      if (pos_c >= ID_FIRST && pos_c < OFS_FIRST) begin
        id_field_next[{pos_c[1:0], 3'b000} +: 8] = req.data;
      end else if (pos_c >= OFS_FIRST && pos_c < PK_FIRST) begin
        offset_field_next[{pos_c[1:0], 3'b000} +: 8] = req.data;
      end else if (pos_c >= PK_FIRST && pos_c < UPK_FIRST) begin
        packed_field_next[{pos_c[1:0], 3'b000} +: 8] = req.data;
      end else if (pos_c >= UPK_FIRST && pos_c < UPK_END) begin
        unpacked_field_next[{pos_c[1:0], 3'b000} +: 8] = req.data;
      end else if (pos_c >= NAME_FIRST && pos_c < NAME_END && !ended_c) begin
        if (req.data == 8'd0) begin
          ended_next = 1'b1;
        end else begin
          hash_next = fnv_step(hash_c, req.data);
        end
      end

      if (pos_c == POS_LAST) begin
        pos_next   = 6'd0;
        hash_next  = adv_pkg::FNV_BASIS;
        ended_next = 1'b0;
        if (is_last) begin
          done_next = 1'b1;
        end else begin
          counter_next = counter_c + 10'd1;
        end
      end else begin
        pos_next = pos_c + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 6'd0;
      counter <= 10'd0;
      hash    <= adv_pkg::FNV_BASIS;
      ended   <= 1'b0;
      done    <= 1'b0;
    end else if (req.step) begin
      pos     <= pos_next;
      counter <= counter_next;
      hash    <= hash_next;
      ended   <= ended_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_field       <= 32'd0;
      offset_field   <= 32'd0;
      packed_field   <= 32'd0;
      unpacked_field <= 32'd0;
    end else if (req.step) begin
      id_field       <= id_field_next;
      offset_field   <= offset_field_next;
      packed_field   <= packed_field_next;
      unpacked_field <= unpacked_field_next;
    end
  end

  assign rec.number       = counter;
  assign rec.is_last      = is_last;
  assign rec.id           = id_field;
  assign rec.offset       = offset_field;
  assign rec.packed_len   = packed_field;
  assign rec.unpacked_len = unpacked_field;
  assign rec.hash         = hash;
  assign rec.name_ended   = ended;

endmodule

`default_nettype wire

// File: sv/adv_judge.sv
// ----------------------------------------------------------------------------
// adv_judge
// Ordered record checks, previous-record history and the sticky pass flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adv_judge (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear,
  input  wire logic             fire,
  input  wire adv_pkg::cfg_t    cfg,
  input  wire adv_pkg::record_t rec,
  output adv_pkg::verdict_t     verdict
);

  logic [31:0]        prior_id;
  logic [31:0]        prior_end;
  logic               failed_flag;
  logic               first;
  adv_pkg::err_code_t code;

  assign first = (rec.number == 10'd0);

  always_comb begin
    priority if (!rec.name_ended) begin
      code = adv_pkg::ERR_UNTERMINATED;
    end else if (rec.id != rec.hash) begin
      code = adv_pkg::ERR_ID_MISMATCH;
    end else if (!first && rec.id <= prior_id) begin
      code = adv_pkg::ERR_ORDER;
    end else if (rec.offset < cfg.data_start) begin
      code = adv_pkg::ERR_BELOW_DATA;
    end else if (rec.offset[adv_pkg::ALIGN_LOG-1:0] != '0) begin
      code = adv_pkg::ERR_MISALIGNED;
    end else if (rec.packed_len != rec.unpacked_len) begin
      code = adv_pkg::ERR_SIZE;
    end else if (rec.packed_len > cfg.file_length ||
                 rec.offset > cfg.file_length - rec.packed_len) begin
      code = adv_pkg::ERR_BEYOND_END;
    end else if (!first && rec.offset < prior_end) begin
      code = adv_pkg::ERR_OVERLAP;
    end else begin
      code = adv_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prior_id    <= 32'd0;
      prior_end   <= 32'd0;
      failed_flag <= 1'b0;
    end else if (fire) begin
      prior_id    <= rec.id;
      prior_end   <= rec.offset + rec.packed_len;
      failed_flag <= failed_flag || (code != adv_pkg::ERR_NONE);
    end
  end

  assign verdict.number = rec.number;
  assign verdict.id     = rec.id;
  assign verdict.code   = code;
  assign verdict.all_ok = !failed_flag && (code == adv_pkg::ERR_NONE);
  assign verdict.last   = rec.is_last;

endmodule

`default_nettype wire

// File: sv/adv_out_reg.sv
// ----------------------------------------------------------------------------
// adv_out_reg
// Result register of the verdict channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adv_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire adv_pkg::verdict_t verdict_in,
  input  wire logic              stall,
  output logic                   valid,
  output adv_pkg::verdict_t      verdict
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict <= verdict_in;
    end
  end

endmodule

`default_nettype wire

// File: sv/asset_directory_validator_top.sv
// ----------------------------------------------------------------------------
// asset_directory_validator_top
// Stream checker for an archive directory made of 64-byte records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one directory byte per
//   request with a restart mark on the first byte of a directory. Output
//   channel (out_valid / out_stall) carries one verdict per record: record
//   number, id, first failing check, the sticky all_ok flag and a last mark.
//   Configuration (cfg_write, cfg_index, cfg_data) sets file length, record
//   count and data start; write it only while the block is idle.
// Timing:
//   One byte per cycle, save for the stall below. The input register holds
//   a byte while the parser, FNV hash and record checks act on it; the
//   verdict for byte 63 goes on into the result register behind out_valid.
// Reset and stall:
//   Reset clears the stream state and loads configuration defaults.
//   While the receiver stalls, the verdict holds in the result register and
//   bytes keep flowing; only a byte that closes a record waits, and then
//   in_stall rises until the verdict is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module asset_directory_validator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // byte requests
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  dir_byte,
  input  wire logic        restart,
  // verdicts
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       record_number,
  output logic [31:0]      record_id,
  output logic [3:0]       error_code,
  output logic             all_ok,
  output logic             last
);

  adv_pkg::cfg_t      cfg;
  adv_pkg::byte_req_t req;
  adv_pkg::record_t   rec;
  adv_pkg::verdict_t  verdict_c;
  adv_pkg::verdict_t  verdict;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_restart;
  logic       ends_record;
  logic       s1_res;
  logic       advance;
  logic       fire;

  // Hold configuration; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.file_length <= 32'd0;
      cfg.entries     <= 11'd1;
      cfg.data_start  <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        adv_pkg::CFG_FILE_LENGTH: cfg.file_length <= cfg_data;
        adv_pkg::CFG_ENTRIES:     cfg.entries     <= cfg_data[10:0];
        adv_pkg::CFG_DATA_START:  cfg.data_start  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input stage unless its byte closes a record and the
  // result register stays full.
  assign s1_res   = !s1_restart && ends_record;
  assign advance  = !s1_res || !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance && s1_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte    <= dir_byte;
      s1_restart <= restart;
    end
  end

  assign req.step    = s1_valid && advance;
  assign req.data    = s1_byte;
  assign req.restart = s1_restart;

  adv_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .entries     (cfg.entries),
    .ends_record (ends_record),
    .rec         (rec)
  );

  adv_judge u_judge (
    .clk     (clk),
    .rst     (rst),
    .clear   (req.step && req.restart),
    .fire    (fire),
    .cfg     (cfg),
    .rec     (rec),
    .verdict (verdict_c)
  );

  adv_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .verdict_in (verdict_c),
    .stall      (out_stall),
    .valid      (out_valid),
    .verdict    (verdict)
  );

  assign record_number = verdict.number;
  assign record_id     = verdict.id;
  assign error_code    = verdict.code;
  assign all_ok        = verdict.all_ok;
  assign last          = verdict.last;

  // A failing verdict always clears the sticky flag.
  `ADV_ASSERT(a_fail_clears_ok, (out_valid && error_code != adv_pkg::ERR_NONE) |-> !all_ok)
  // Input back-pressure only comes from a held result.
  `ADV_ASSERT(a_stall_cause, in_stall |-> (s1_valid && out_valid && out_stall))
  // Never load a verdict over one that is still held.
  `ADV_ASSERT_NEVER(a_no_overwrite, fire && out_valid && out_stall)

endmodule

`default_nettype wire
